### design/circle_rasterizer_macros.svh
// ----------------------------------------------------------------------------
// circle_rasterizer assertion macros
// Shared concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CIRCLE_RASTERIZER_MACROS_SVH
`define CIRCLE_RASTERIZER_MACROS_SVH

// Same-cycle implication
`define CRAST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CRAST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/crast_pkg.sv
// ----------------------------------------------------------------------------
// crast_pkg
// Types and constants for the circle rasterizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package crast_pkg;

  localparam int COLOR_BITS = 8;

  // Request kind carried on tuser
  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_t;

  // Stored point color, red in the upper byte
  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } color_t;

endpackage

### design/circle_rasterizer.sv
// ----------------------------------------------------------------------------
// circle_rasterizer
// A step's four points are registered into m_axis, or into the skid stage if
// m_axis stalls. One transaction per cycle while the skid is empty; the offset
// and its squares are registers updated incrementally by one add/compare stage.
// Reset: block idle, no circle loaded, output and skid stages empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "circle_rasterizer_macros.svh"

module circle_rasterizer
  import crast_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  // slave side
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // center_x, center_y, radius, red, green, blue (zero padded to bytes)
  input  logic [((3*COORD_BITS+23+7)/8)*8-1:0]   s_axis_tdata,
  // req_type
  input  logic                                   s_axis_tuser,
  // master side
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pd_x, pd_y, out_red, out_green, out_blue
  output logic [8*(COORD_BITS+1)+3*COLOR_BITS-1:0] m_axis_tdata,
  // last_step
  output logic                                   m_axis_tlast
);

  localparam int CW    = COORD_BITS;
  localparam int PW    = COORD_BITS + 1;
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int E_W   = 2 * COORD_BITS + 3;
  localparam int OUT_W = 8 * PW + 3 * COLOR_BITS;
  localparam logic signed [E_W-1:0] ONE_E = E_W'(1);

  // Input unpacking
  logic               acc;
  req_t               req;
  logic signed [CW-1:0] in_cx;
  logic signed [CW-1:0] in_cy;
  logic [CW-2:0]      in_rad;
  color_t             in_color;
  logic [SQ_W-3:0]    rad_sq;

  assign acc      = s_axis_tvalid && s_axis_tready;
  assign req      = req_t'(s_axis_tuser);
  assign in_cx    = s_axis_tdata[CW-1:0];
  assign in_cy    = s_axis_tdata[2*CW-1:CW];
  assign in_rad   = s_axis_tdata[3*CW-2:2*CW];
  assign in_color.red   = s_axis_tdata[3*CW-1+COLOR_BITS-1:3*CW-1];
  assign in_color.green = s_axis_tdata[3*CW-1+2*COLOR_BITS-1:3*CW-1+COLOR_BITS];
  assign in_color.blue  = s_axis_tdata[3*CW-1+3*COLOR_BITS-1:3*CW-1+2*COLOR_BITS];
  assign rad_sq   = (SQ_W-2)'(in_rad) * (SQ_W-2)'(in_rad);

  // Circle state
  logic                 busy;
  logic [CW-1:0]        ox;
  logic signed [CW:0]   oy;
  logic [SQ_W-1:0]      x2;
  logic [SQ_W-1:0]      y2;
  logic [SQ_W-1:0]      r2;
  logic signed [CW-1:0] cx;
  logic signed [CW-1:0] cy;
  logic [CW-2:0]        rad;
  color_t               color;

  // Squared error terms from the incremental squares
  logic signed [E_W-1:0] xe, ye, x2e, y2e, r2e;
  logic signed [E_W-1:0] xp, ym;
  logic signed [E_W-1:0] err_h, err_d, err_v;
  logic signed [E_W-1:0] mag_h, mag_d, mag_v;
  logic                  mv_x, mv_y;

  assign xe  = {{(E_W-CW){1'b0}}, ox};
  assign ye  = {{(E_W-CW-1){oy[CW]}}, oy};
  assign x2e = {{(E_W-SQ_W){1'b0}}, x2};
  assign y2e = {{(E_W-SQ_W){1'b0}}, y2};
  assign r2e = {{(E_W-SQ_W){1'b0}}, r2};

  assign xp    = x2e + xe + xe + ONE_E;
  assign ym    = y2e - ye - ye + ONE_E;
  assign err_h = xp + y2e - r2e;
  assign err_d = xp + ym - r2e;
  assign err_v = x2e + ym - r2e;
  assign mag_h = err_h[E_W-1] ? -err_h : err_h;
  assign mag_d = err_d[E_W-1] ? -err_d : err_d;
  assign mag_v = err_v[E_W-1] ? -err_v : err_v;

  // Move selection
  always_comb begin
    if (err_d < 0) begin
      mv_x = 1'b1;
      mv_y = (mag_h > mag_d);
    end else if (err_d > 0) begin
      mv_y = 1'b1;
      mv_x = (mag_d <= mag_v);
    end else begin
      mv_x = 1'b1;
      mv_y = 1'b1;
    end
  end

  // Next offset and squares
  logic [CW-1:0]      x_next;
  logic signed [CW:0] y_next;
  logic [SQ_W-1:0]    x2_next;
  logic [SQ_W-1:0]    y2_next;
  logic               last_next;
  logic               res_valid;

  assign x_next    = ox + CW'(mv_x);
  assign y_next    = oy - $signed({{CW{1'b0}}, mv_y});
  assign x2_next   = mv_x ? xp[SQ_W-1:0] : x2;
  assign y2_next   = mv_y ? ym[SQ_W-1:0] : y2;
  assign last_next = ({1'b0, x_next} > {2'b00, rad}) || y_next[CW];
  assign res_valid = acc && (req == REQ_STEP) && busy;

  // Mirrored points
  logic [PW-1:0] cxe, cye, xz;
  logic [PW-1:0] px_pos, px_neg, py_pos, py_neg;
  logic [OUT_W-1:0] res_data;

  assign cxe    = {cx[CW-1], cx};
  assign cye    = {cy[CW-1], cy};
  assign xz     = {1'b0, x_next};
  assign px_pos = cxe + xz;
  assign px_neg = cxe - xz;
  assign py_pos = cye + y_next;
  assign py_neg = cye - y_next;
  assign res_data = {color.blue, color.green, color.red,
                     py_pos, px_neg, py_neg, px_pos,
                     py_neg, px_neg, py_pos, px_pos};

  // Busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (acc) begin
      if (req == REQ_START) begin
        busy <= 1'b1;
      end else if (busy && last_next) begin
        busy <= 1'b0;
      end
    end
  end

  // Circle payload
  always_ff @(posedge clk) begin
    if (acc && (req == REQ_START)) begin
      cx    <= in_cx;
      cy    <= in_cy;
      rad   <= in_rad;
      color <= in_color;
      ox    <= '0;
      oy    <= {2'b00, in_rad};
      x2    <= '0;
      y2    <= {2'b00, rad_sq};
      r2    <= {2'b00, rad_sq};
    end else if (res_valid) begin
      ox <= x_next;
      oy <= y_next;
      x2 <= x2_next;
      y2 <= y2_next;
    end
  end

  // Output register with skid stage
  logic             skid_valid;
  logic [OUT_W-1:0] skid_data;
  logic             skid_last;
  logic             out_load;

  assign s_axis_tready = !skid_valid;
  assign out_load      = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (out_load) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (skid_valid) begin
        m_axis_tdata <= skid_data;
        m_axis_tlast <= skid_last;
      end else begin
        m_axis_tdata <= res_data;
        m_axis_tlast <= last_next;
      end
    end else if (res_valid) begin
      skid_data <= res_data;
      skid_last <= last_next;
    end
  end

  // Checks
  `CRAST_ASSERT_SAME(a_skid_behind_out, skid_valid, m_axis_tvalid, "skid full with output empty")
  `CRAST_ASSERT_NEXT(a_last_clears_busy, res_valid && last_next, !busy, "busy after last step")
  `CRAST_ASSERT_SAME(a_busy_y_nonneg, busy, !oy[CW], "negative y offset while busy")
  `CRAST_ASSERT_SAME(a_busy_x_in_range, busy, ({1'b0, ox} <= {2'b00, rad}), "x offset past radius")

endmodule

### dv/tb_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_circle_rasterizer
// Self-checking bench for the Bresenham circle rasterizer. Start and step
// transactions are queued up front: a directed part for the corner cases, then
// random circles run to completion or dropped part way. Both stream sides idle
// and stall at random. Every accepted step transaction is predicted and the
// four mirrored points, the color and tlast are checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_circle_rasterizer;
  import crast_pkg::*;

  localparam int COORD_BITS = 12;
  localparam int RAD_BITS   = COORD_BITS - 1;
  localparam int PW         = COORD_BITS + 1;
  localparam int IN_W       = ((3*COORD_BITS+23+7)/8)*8;
  localparam int OUT_W      = 8*PW + 3*COLOR_BITS;
  localparam int ITEM_GOAL  = 700;
  localparam int CYCLE_LIMIT = 400000;

  // receiver stall patterns
  localparam int RX_ALWAYS  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PERIOD  = 2;
  localparam int RX_SPARSE  = 3;

  // start fields, first field in the low bits
  typedef struct packed {
    logic [IN_W-3*COORD_BITS-23-1:0] pad;
    logic [COLOR_BITS-1:0]           blue;
    logic [COLOR_BITS-1:0]           green;
    logic [COLOR_BITS-1:0]           red;
    logic [RAD_BITS-1:0]             radius;
    logic signed [COORD_BITS-1:0]    center_y;
    logic signed [COORD_BITS-1:0]    center_x;
  } circle_req_t;

  // four mirrored points plus color, first field in the low bits
  typedef struct packed {
    logic [COLOR_BITS-1:0] blue;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] red;
    logic signed [PW-1:0]  pd_y;
    logic signed [PW-1:0]  pd_x;
    logic signed [PW-1:0]  pc_y;
    logic signed [PW-1:0]  pc_x;
    logic signed [PW-1:0]  pb_y;
    logic signed [PW-1:0]  pb_x;
    logic signed [PW-1:0]  pa_y;
    logic signed [PW-1:0]  pa_x;
  } point_set_t;

  typedef struct packed {
    point_set_t pts;
    logic       last;
  } step_points_t;

  typedef struct packed {
    req_t        kind;
    circle_req_t data;
  } raster_req_t;

  typedef struct {
    longint ox;
    longint oy;
    longint cx;
    longint cy;
    longint rad;
    color_t color;
    bit     busy;
  } circle_state_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // center_x, center_y, radius, red, green, blue, zero pad
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  // req_type
  logic             s_axis_tuser  = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // pa_x, pa_y, pb_x, pb_y, pc_x, pc_y, pd_x, pd_y, out_red, out_green, out_blue
  logic [OUT_W-1:0] m_axis_tdata;
  // last_step
  logic             m_axis_tlast;

  raster_req_t   pending_reqs[$];
  step_points_t  expected_steps[$];
  circle_state_t gen_circle;
  circle_state_t dut_circle;
  int            gen_count  = 0;
  int            mismatches = 0;
  int            cycle_count = 0;
  bit            in_taken   = 1'b0;
  int            burst_left = 1;
  int            gap_left   = 0;
  int            rx_mode    = RX_ALWAYS;
  int            rx_left    = 0;
  int            rx_phase   = 0;

  circle_rasterizer #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  // Bresenham step: returns 1 when the transaction yields a point set
  function automatic bit rasterize_step(inout circle_state_t st, input req_t kind,
                                        input circle_req_t req, output step_points_t res);
    longint x, y, r2, d, eh, ed, ev;
    res = '0;
    if (kind == REQ_START) begin
      st.cx    = $signed(req.center_x);
      st.cy    = $signed(req.center_y);
      st.rad   = req.radius;
      st.color = {req.red, req.green, req.blue};
      st.ox    = 0;
      st.oy    = st.rad;
      st.busy  = 1'b1;
      return 1'b0;
    end
    if (!st.busy) return 1'b0;

    x  = st.ox;
    y  = st.oy;
    r2 = st.rad * st.rad;
    d  = (x + 1) * (x + 1) + (y - 1) * (y - 1) - r2;
    eh = (x + 1) * (x + 1) + y * y - r2;
    ev = x * x + (y - 1) * (y - 1) - r2;
    ed = (d < 0) ? -d : d;
    if (eh < 0) eh = -eh;
    if (ev < 0) ev = -ev;

    // pick horizontal, diagonal or vertical move
    if (d < 0) begin
      x = x + 1;
      if (eh > ed) y = y - 1;
    end else if (d > 0) begin
      y = y - 1;
      if (ed <= ev) x = x + 1;
    end else begin
      x = x + 1;
      y = y - 1;
    end
    st.ox = x;
    st.oy = y;

    res.pts.pa_x  = PW'(st.cx + x);
    res.pts.pa_y  = PW'(st.cy + y);
    res.pts.pb_x  = PW'(st.cx - x);
    res.pts.pb_y  = PW'(st.cy - y);
    res.pts.pc_x  = PW'(st.cx + x);
    res.pts.pc_y  = PW'(st.cy - y);
    res.pts.pd_x  = PW'(st.cx - x);
    res.pts.pd_y  = PW'(st.cy + y);
    res.pts.red   = st.color.red;
    res.pts.green = st.color.green;
    res.pts.blue  = st.color.blue;
    res.last      = (x > st.rad) || (y < 0);
    if (res.last) st.busy = 1'b0;
    return 1'b1;
  endfunction

  // queue one transaction; the generator tracks the circle to know its end
  task automatic push_req(input req_t kind, input int cx, input int cy, input int rad,
                          input int red, input int green, input int blue,
                          output bit last);
    raster_req_t  item;
    step_points_t res;
    item.kind            = kind;
    item.data            = '0;
    item.data.center_x   = cx[COORD_BITS-1:0];
    item.data.center_y   = cy[COORD_BITS-1:0];
    item.data.radius     = rad[RAD_BITS-1:0];
    item.data.red        = red[7:0];
    item.data.green      = green[7:0];
    item.data.blue       = blue[7:0];
    pending_reqs.insert(pending_reqs.size(), item);
    last = 1'b0;
    if (rasterize_step(gen_circle, kind, item.data, res)) begin
      last = res.last;
      gen_count++;
    end else if (kind == REQ_START) begin
      gen_count++;
    end
  endtask

  // step the generator's circle until its last point set
  task automatic finish_circle();
    bit last;
    last = 1'b0;
    while (!last)
      push_req(REQ_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, last);
  endtask

  task automatic compare_field(input string field, input longint want, input longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("@%0t mismatch on %s: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // stimulus plan, reset and end of run
  initial begin : stimulus
    bit last;
    int rad;
    gen_circle = '{default: 0};
    dut_circle = '{default: 0};

    // step while idle, then radius zero at the coordinate extremes
    push_req(REQ_STEP, 2047, -2048, 2047, 255, 255, 255, last);
    push_req(REQ_STEP, -2048, 2047, 0, 0, 0, 0, last);
    push_req(REQ_START, -2048, 2047, 0, 0, 0, 0, last);
    push_req(REQ_STEP, 0, 0, 0, 0, 0, 0, last);
    push_req(REQ_STEP, 0, 0, 0, 0, 0, 0, last);
    // largest radius, dropped by a start while busy
    push_req(REQ_START, 2047, -2048, 2047, 255, 255, 255, last);
    repeat (3) push_req(REQ_STEP, 0, 0, 0, 0, 0, 0, last);
    push_req(REQ_START, 0, 0, 5, 255, 0, 170, last);
    finish_circle();
    push_req(REQ_STEP, -1, -1, 2047, 255, 255, 255, last);
    push_req(REQ_START, -2048, -2048, 1, 85, 170, 15, last);
    finish_circle();
    push_req(REQ_START, 2047, 2047, 2047, 1, 2, 3, last);
    push_req(REQ_STEP, 0, 0, 0, 0, 0, 0, last);
    push_req(REQ_START, 2047, 2047, 2, 128, 64, 32, last);
    finish_circle();

    // random circles, most run to the end, some dropped, some idle noise
    while (gen_count < ITEM_GOAL) begin
      rad = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 24) : $urandom_range(0, 2047);
      push_req(REQ_START, $urandom, $urandom, rad, $urandom, $urandom, $urandom, last);
      if (rad <= 40 && $urandom_range(0, 9) < 8) begin
        finish_circle();
      end else begin
        repeat ($urandom_range(0, 30)) begin
          if (!last)
            push_req(REQ_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     last);
        end
      end
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3))
          push_req(REQ_STEP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   last);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb_circle_rasterizer passed");
    end else begin
      $display("tb_circle_rasterizer failed");
    end
    $finish;
  end

  // sender: bursts of transactions separated by random gaps
  always @(negedge clk) begin : sender
    raster_req_t item;
    logic        nxt_valid;
    nxt_valid = s_axis_tvalid;
    if (!rst && (!s_axis_tvalid || in_taken)) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_reqs.size() > 0) begin
        item = pending_reqs.pop_front();
        s_axis_tdata <= item.data;
        s_axis_tuser <= item.kind;
        nxt_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 32);
          case ($urandom_range(0, 9))
            0, 1, 2, 3: gap_left = 0;
            9:          gap_left = $urandom_range(10, 30);
            default:    gap_left = $urandom_range(1, 6);
          endcase
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
  end

  // receiver: stall pattern is redrawn at random from four modes, run after run
  always @(negedge clk) begin : receiver
    if (rx_left == 0) begin
      rx_mode = $urandom_range(RX_ALWAYS, RX_SPARSE);
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_ALWAYS: m_axis_tready <= 1'b1;
      RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
      RX_PERIOD: m_axis_tready <= (rx_phase % 5) != 0;
      default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // monitor: check delivered point sets, predict accepted transactions
  always @(posedge clk) begin : monitor
    point_set_t   got;
    step_points_t want;
    step_points_t res;
    if (rst) begin
      in_taken = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_steps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("@%0t unexpected point set %h, tlast %b", $time, m_axis_tdata,
                     m_axis_tlast);
        end else begin
          want = expected_steps.pop_front();
          compare_field("pa_x", want.pts.pa_x, got.pa_x);
          compare_field("pa_y", want.pts.pa_y, got.pa_y);
          compare_field("pb_x", want.pts.pb_x, got.pb_x);
          compare_field("pb_y", want.pts.pb_y, got.pb_y);
          compare_field("pc_x", want.pts.pc_x, got.pc_x);
          compare_field("pc_y", want.pts.pc_y, got.pc_y);
          compare_field("pd_x", want.pts.pd_x, got.pd_x);
          compare_field("pd_y", want.pts.pd_y, got.pd_y);
          compare_field("out_red", want.pts.red, got.red);
          compare_field("out_green", want.pts.green, got.green);
          compare_field("out_blue", want.pts.blue, got.blue);
          compare_field("last_step", want.last, m_axis_tlast);
        end
      end
      in_taken = s_axis_tvalid && s_axis_tready;
      if (in_taken) begin
        if (rasterize_step(dut_circle, req_t'(s_axis_tuser), s_axis_tdata, res))
          expected_steps.insert(expected_steps.size(), res);
      end
    end
  end

  // run limit
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_circle_rasterizer failed");
      $finish;
    end
  end

endmodule
